### rtl/page_block_allocator_defines.svh
// Assertion macros shared by the page block allocator RTL.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef PAGE_BLOCK_ALLOCATOR_DEFINES_SVH
`define PAGE_BLOCK_ALLOCATOR_DEFINES_SVH

// ante holds in a cycle -> cons holds in that same cycle
`define PBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante holds in a cycle -> cons holds in the next cycle
`define PBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pba_pkg.sv
// Types, codes and constants of the page block allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pba_pkg;

    localparam int BLOCK_BYTES     = 16;
    localparam int HEAD_BLOCKS     = 1;
    localparam int MIN_REGION      = 1 + HEAD_BLOCKS;
    localparam int MAX_PAGE_BLOCKS = 4096;
    localparam int MIN_PAGE_BLOCKS = 2;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_REALLOC = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIT,
        S_FIND,
        S_REL,
        S_RIGHT,
        S_LEFT,
        S_DROP_RD,
        S_DROP_WR,
        S_RESP
    } t_state;

    // data blocks for a byte count; zero counts as one byte
    function automatic logic [13:0] data_blocks_for(input logic [16:0] bytes);
        logic [17:0] t;
        t = ((bytes == 17'd0) ? 18'd1 : {1'b0, bytes}) + 18'(BLOCK_BYTES - 1);
        return 14'(t / BLOCK_BYTES);
    endfunction

endpackage
`default_nettype wire

### rtl/pba_if.sv
// Valid/ready channel interfaces for command and result transfers.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface pba_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [16:0] size_bytes;
    logic [11:0] alloc_offset;
    logic [11:0] alloc_blocks;
    modport source (output valid, command, size_bytes, alloc_offset, alloc_blocks,
                    input ready);
    modport sink   (input valid, command, size_bytes, alloc_offset, alloc_blocks,
                    output ready);
endinterface

interface pba_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [11:0] result_offset;
    logic [11:0] result_blocks;
    logic        moved;
    modport source (output valid, status, result_offset, result_blocks, moved,
                    input ready);
    modport sink   (input valid, status, result_offset, result_blocks, moved,
                    output ready);
endinterface
`default_nettype wire

### rtl/page_block_allocator.sv
// Page block allocator top level: command sequencer around the free-region table RAM.
// Depends on pba_pkg, pba_if, pba_ram and page_block_allocator_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "page_block_allocator_defines.svh"
// First-fit allocator for one page of 16-byte blocks. Each allocation is a one-block
// header plus its data blocks. Free space lives in a bump head and an unordered table
// of FREE_SLOTS regions held in one RAM (start and size per entry). Commands are
// allocate, free and reallocate; one result per command. Commands are handled one at
// a time. Every table search reads one entry per cycle until a hit or the table end;
// allocate needs one search, free two (right then left neighbor), and a reallocate
// that moves up to four (find neighbor, fit, right, left). Removing an entry takes a
// read state and a write state (S_DROP_RD, S_DROP_WR) that copy the last entry into
// the removed slot. A new command is accepted while the previous result still waits
// in the output register. page_blocks may be written only while idle; it is clamped
// to 2..4096.
module page_block_allocator #(
    parameter int FREE_SLOTS = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [12:0] i_cfg_data,
    pba_cmd_if.sink     i_cmd,
    pba_res_if.source   o_res
);
    import pba_pkg::*;

    localparam int AW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int CW = $clog2(FREE_SLOTS + 1);
    localparam int DW = 25;   // {start[12:0], size[11:0]}

    // control state
    t_state        r_state, n_state;
    t_state        r_after, n_after;     // where to go after an entry removal
    logic [12:0]   r_page;
    logic [12:0]   r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;         // next entry to read
    logic          r_pend, n_pend;       // read data valid for r_pidx
    logic [AW-1:0] r_pidx, n_pidx;
    logic [AW-1:0] r_j, n_j;             // entry to remove
    logic          r_listed, n_listed;
    logic          r_ov, n_ov;

    // working registers
    logic [1:0]    r_cmd, n_cmd;
    logic [11:0]   r_s, n_s;
    logic [11:0]   r_n, n_n;
    logic [13:0]   r_req, n_req;
    logic [13:0]   r_need, n_need;
    logic [13:0]   r_key, n_key;
    logic [12:0]   r_js, n_js;
    logic [11:0]   r_jn, n_jn;
    logic [1:0]    r_status, n_status;
    logic [11:0]   r_roff, n_roff;
    logic [11:0]   r_rblk, n_rblk;
    logic          r_mv, n_mv;

    // output payload
    logic [1:0]    r_o_status;
    logic [11:0]   r_o_roff;
    logic [11:0]   r_o_rblk;
    logic          r_o_mv;
    logic          load_out;

    // RAM
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [DW-1:0] ram_wdata, ram_rdata;

    pba_ram #(.WIDTH(DW), .DEPTH(FREE_SLOTS)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // datapath terms
    logic [12:0] rd_st;
    logic [11:0] rd_sz;
    logic [14:0] ue;
    logic [13:0] avail;
    logic        fit_ok, split;
    logic        m_start, m_left, hit, miss;
    logic        head_fit;
    logic [13:0] in_req, in_nx, rel_nx;
    logic        cmd_xfer;

    assign rd_st    = ram_rdata[24:12];
    assign rd_sz    = ram_rdata[11:0];
    assign ue       = 15'(r_page - 13'(HEAD_BLOCKS));
    assign avail    = 14'(rd_sz) + 14'(HEAD_BLOCKS);
    assign fit_ok   = avail >= r_need;
    assign split    = avail >= (r_need + 14'(MIN_REGION));
    assign m_start  = 14'(rd_st) == r_key;
    assign m_left   = (14'(rd_st) + 14'(rd_sz) + 14'(HEAD_BLOCKS)) == r_key;
    assign head_fit = (15'(r_head) + 15'(r_need)) <= ue;
    assign in_req   = data_blocks_for(i_cmd.size_bytes);
    assign in_nx    = 14'(i_cmd.alloc_offset) + 14'(i_cmd.alloc_blocks) + 14'(HEAD_BLOCKS);
    assign rel_nx   = 14'(r_s) + 14'(r_n) + 14'(HEAD_BLOCKS);
    assign miss     = !r_pend && (r_idx >= r_count);

    always_comb begin
        case (r_state)
            S_FIT:   hit = r_pend && fit_ok;
            S_LEFT:  hit = r_pend && m_left;
            S_FIND,
            S_RIGHT: hit = r_pend && m_start;
            default: hit = 1'b0;
        endcase
    end

    assign i_cmd.ready = (r_state == S_IDLE);
    assign cmd_xfer    = i_cmd.valid && i_cmd.ready;

    assign o_res.valid         = r_ov;
    assign o_res.status        = r_o_status;
    assign o_res.result_offset = r_o_roff;
    assign o_res.result_blocks = r_o_rblk;
    assign o_res.moved         = r_o_mv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_after  <= S_RESP;
            r_page   <= 13'(MAX_PAGE_BLOCKS);
            r_head   <= '0;
            r_count  <= '0;
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_listed <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_after  <= n_after;
            r_head   <= n_head;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_pend   <= n_pend;
            r_listed <= n_listed;
            r_ov     <= n_ov;
            if (i_cfg_we) begin
                if (i_cfg_data < 13'(MIN_PAGE_BLOCKS)) begin
                    r_page <= 13'(MIN_PAGE_BLOCKS);
                end else if (i_cfg_data > 13'(MAX_PAGE_BLOCKS)) begin
                    r_page <= 13'(MAX_PAGE_BLOCKS);
                end else begin
                    r_page <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx   <= n_pidx;
        r_j      <= n_j;
        r_cmd    <= n_cmd;
        r_s      <= n_s;
        r_n      <= n_n;
        r_req    <= n_req;
        r_need   <= n_need;
        r_key    <= n_key;
        r_js     <= n_js;
        r_jn     <= n_jn;
        r_status <= n_status;
        r_roff   <= n_roff;
        r_rblk   <= n_rblk;
        r_mv     <= n_mv;
        if (load_out) begin
            r_o_status <= r_status;
            r_o_roff   <= r_roff;
            r_o_rblk   <= r_rblk;
            r_o_mv     <= r_mv;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_after  = r_after;
        n_head   = r_head;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pend   = 1'b0;
        n_pidx   = r_pidx;
        n_j      = r_j;
        n_listed = r_listed;
        n_ov     = r_ov && !o_res.ready;
        n_cmd    = r_cmd;
        n_s      = r_s;
        n_n      = r_n;
        n_req    = r_req;
        n_need   = r_need;
        n_key    = r_key;
        n_js     = r_js;
        n_jn     = r_jn;
        n_status = r_status;
        n_roff   = r_roff;
        n_rblk   = r_rblk;
        n_mv     = r_mv;
        load_out = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_pidx;
        ram_wdata = ram_rdata;
        ram_raddr = r_idx[AW-1:0];

        // table walk: one read issued per cycle until a hit or the end
        if ((r_state == S_FIT) || (r_state == S_FIND) ||
            (r_state == S_RIGHT) || (r_state == S_LEFT)) begin
            if (!hit && (r_idx < r_count)) begin
                n_pend = 1'b1;
                n_pidx = r_idx[AW-1:0];
                n_idx  = r_idx + CW'(1);
            end
        end

        case (r_state)
            S_IDLE: begin
                if (cmd_xfer) begin
                    n_cmd    = i_cmd.command;
                    n_s      = i_cmd.alloc_offset;
                    n_n      = i_cmd.alloc_blocks;
                    n_req    = in_req;
                    n_status = ST_OK;
                    n_roff   = '0;
                    n_rblk   = '0;
                    n_mv     = 1'b0;
                    n_state  = S_RESP;
                    case (i_cmd.command)
                        CMD_ALLOC: begin
                            n_need  = in_req + 14'(HEAD_BLOCKS);
                            n_state = S_FIT;
                        end
                        CMD_FREE: begin
                            n_roff = i_cmd.alloc_offset;
                            if (in_nx == 14'(r_head)) begin
                                n_head = 13'(i_cmd.alloc_offset);
                            end else begin
                                n_js    = 13'(i_cmd.alloc_offset);
                                n_jn    = i_cmd.alloc_blocks;
                                n_key   = in_nx;
                                n_state = S_RIGHT;
                            end
                        end
                        CMD_REALLOC: begin
                            n_roff = i_cmd.alloc_offset;
                            n_rblk = i_cmd.alloc_blocks;
                            if (14'(i_cmd.alloc_blocks) >= (in_req + 14'(MIN_REGION))) begin
                                // shrink in place; tail goes to head or table
                                n_rblk = in_req[11:0];
                                if (in_nx == 14'(r_head)) begin
                                    n_head = r_head - 13'(i_cmd.alloc_blocks - in_req[11:0]);
                                end else begin
                                    n_js    = 13'(i_cmd.alloc_offset) + 13'(in_req)
                                              + 13'(HEAD_BLOCKS);
                                    n_jn    = i_cmd.alloc_blocks - in_req[11:0]
                                              - 12'(HEAD_BLOCKS);
                                    n_key   = in_nx;
                                    n_state = S_RIGHT;
                                end
                            end else if (14'(i_cmd.alloc_blocks) < in_req) begin
                                // grow: in place into the head or the free region right after, else move
                                n_need = in_req - 14'(i_cmd.alloc_blocks);
                                n_key  = in_nx;
                                if (in_nx == 14'(r_head)) begin
                                    if ((15'(r_head) + 15'(in_req - 14'(i_cmd.alloc_blocks)))
                                        <= ue) begin
                                        n_head = 13'(14'(r_head) + in_req
                                                 - 14'(i_cmd.alloc_blocks));
                                        n_rblk = in_req[11:0];
                                    end else begin
                                        n_need  = in_req + 14'(HEAD_BLOCKS);
                                        n_state = S_FIT;
                                    end
                                end else begin
                                    n_state = S_FIND;
                                end
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            S_FIT: begin
                if (hit) begin
                    n_roff = rd_st[11:0];
                    n_mv   = (r_cmd == CMD_REALLOC);
                    if (split) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_pidx;
                        ram_wdata = {1'b0, rd_st[11:0] + r_need[11:0], rd_sz - r_need[11:0]};
                        n_rblk    = r_req[11:0];
                        n_state   = (r_cmd == CMD_ALLOC) ? S_RESP : S_REL;
                    end else begin
                        n_rblk  = rd_sz;
                        n_j     = r_pidx;
                        n_after = (r_cmd == CMD_ALLOC) ? S_RESP : S_REL;
                        n_state = S_DROP_RD;
                    end
                end else if (miss) begin
                    if (head_fit) begin
                        n_roff  = r_head[11:0];
                        n_head  = r_head + r_need[12:0];
                        n_rblk  = r_req[11:0];
                        n_mv    = (r_cmd == CMD_REALLOC);
                        n_state = (r_cmd == CMD_ALLOC) ? S_RESP : S_REL;
                    end else begin
                        // failed: allocate reports zeros, reallocate the old region
                        n_status = ST_NOSPACE;
                        n_state  = S_RESP;
                    end
                end
            end

            S_FIND: begin
                if (hit && fit_ok) begin
                    if (split) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_pidx;
                        ram_wdata = {1'b0, rd_st[11:0] + r_need[11:0], rd_sz - r_need[11:0]};
                        n_rblk    = r_n + r_need[11:0];
                        n_state   = S_RESP;
                    end else begin
                        n_rblk  = r_n + rd_sz + 12'(HEAD_BLOCKS);
                        n_j     = r_pidx;
                        n_after = S_RESP;
                        n_state = S_DROP_RD;
                    end
                end else if (hit || miss) begin
                    n_need  = r_req + 14'(HEAD_BLOCKS);
                    n_state = S_FIT;
                end
            end

            S_REL: begin
                // old region of a moved allocation
                if (rel_nx == 14'(r_head)) begin
                    n_head  = 13'(r_s);
                    n_state = S_RESP;
                end else begin
                    n_js    = 13'(r_s);
                    n_jn    = r_n;
                    n_key   = rel_nx;
                    n_state = S_RIGHT;
                end
            end

            S_RIGHT: begin
                n_key = 14'(r_js);
                if (hit) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pidx;
                    ram_wdata = {r_js, r_jn + rd_sz + 12'(HEAD_BLOCKS)};
                    n_jn      = r_jn + rd_sz + 12'(HEAD_BLOCKS);
                    n_listed  = 1'b1;
                    n_j       = r_pidx;
                    n_state   = S_LEFT;
                end else if (miss) begin
                    n_listed = 1'b0;
                    n_state  = S_LEFT;
                end else begin
                    n_key = r_key;
                end
            end

            S_LEFT: begin
                if (hit) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pidx;
                    ram_wdata = {rd_st, rd_sz + r_jn + 12'(HEAD_BLOCKS)};
                    n_after   = S_RESP;
                    n_state   = r_listed ? S_DROP_RD : S_RESP;
                end else if (miss) begin
                    n_state = S_RESP;
                    if (!r_listed) begin
                        if (r_count >= CW'(FREE_SLOTS)) begin
                            n_status = ST_FULL;   // region dropped on the floor
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = r_count[AW-1:0];
                            ram_wdata = {r_js, r_jn};
                            n_count   = r_count + CW'(1);
                        end
                    end
                end
            end

            S_DROP_RD: begin
                // last entry moves into the removed slot
                n_count   = r_count - CW'(1);
                ram_raddr = AW'(r_count - CW'(1));
                n_state   = S_DROP_WR;
            end

            S_DROP_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = ram_rdata;
                n_state   = r_after;
            end

            S_RESP: begin
                if (!r_ov || o_res.ready) begin
                    load_out = 1'b1;
                    n_ov     = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (n_state != r_state) begin
            n_idx  = '0;
            n_pend = 1'b0;
        end
    end

    `PBA_ASSERT_IMP(a_count_range, 1'b1, r_count <= CW'(FREE_SLOTS), "free count past table size")
    `PBA_ASSERT_IMP(a_head_range, 1'b1, r_head < 13'(MAX_PAGE_BLOCKS), "head past page")
    `PBA_ASSERT_NXT(a_cmd_leaves_idle, cmd_xfer, r_state != S_IDLE, "command not processed")
    `PBA_ASSERT_NXT(a_result_loaded, load_out, r_ov && (r_state == S_IDLE), "result not posted")

endmodule
`default_nettype wire

### rtl/pba_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pba_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
